[design/igl_pkg.sv]
// Package for integer_gcd_lcm: payload structs, status and command codes, sequencer states.
// No dependencies.
package igl_pkg;

    localparam int DATA_WIDTH = 64;
    localparam int CNT_W      = $clog2(DATA_WIDTH + 1);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_UNDEF    = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic {
        CMD_GCD = 1'b0,
        CMD_LCM = 1'b1
    } command_t;

    typedef struct packed {
        logic        command;
        logic [63:0] operand_a;
        logic [63:0] operand_b;
    } in_beat_t;

    typedef struct packed {
        logic [62:0] value;
        logic [1:0]  status;
    } out_beat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_GCD_STEP,
        S_MUL,
        S_DONE
    } state_t;

endpackage

[design/integer_gcd_lcm.sv]
// integer_gcd_lcm: gcd or lcm of two positive signed integers.
// gcd takes one divider pass per Euclid remainder step; lcm adds
// one more division and a shift-add multiply.
// Throughput: one beat at a time; s_ready is high only while idle. All divisions go
// through one shared bit-serial divider; the multiply is a separate shift-add loop in the sequencer.
// Reset (aresetn low, synchronous) returns to idle with no result pending.
module integer_gcd_lcm (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  igl_pkg::in_beat_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output igl_pkg::out_beat_t m_data
);
    import igl_pkg::*;

    localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    state_t                state_reg, state_next;
    logic [DATA_WIDTH-1:0] x_reg, x_next;      // larger / dividend
    logic [DATA_WIDTH-1:0] y_reg, y_next;      // divisor
    logic [DATA_WIDTH-1:0] a_reg, a_next;
    logic [DATA_WIDTH-1:0] b_reg, b_next;
    logic                  cmd_reg, cmd_next;
    logic                  lcmdiv_reg, lcmdiv_next; // divider running a / gcd
    logic [DATA_WIDTH:0]   acc_reg, acc_next;   // multiply accumulator with overflow bit
    logic [DATA_WIDTH-1:0] mq_reg, mq_next;     // multiplier bits, shifted out LSB first
    logic [DATA_WIDTH:0]   mb_reg, mb_next;     // shifted multiplicand
    logic                  ovf_reg, ovf_next;
    out_beat_t             out_reg, out_next;
    logic                  mv_reg, mv_next;
    logic                  div_start;
    logic                  div_done;
    logic [DATA_WIDTH-1:0] div_q, div_r;
    logic [DATA_WIDTH-1:0] op_a, op_b;
    logic                  a_pos, b_pos;
    logic [DATA_WIDTH:0]   acc_sum;

    assign op_a  = s_data.operand_a[DATA_WIDTH-1:0];
    assign op_b  = s_data.operand_b[DATA_WIDTH-1:0];
    assign a_pos = (op_a != '0) && !op_a[DATA_WIDTH-1];
    assign b_pos = (op_b != '0) && !op_b[DATA_WIDTH-1];
    assign acc_sum = acc_reg + mb_reg;

    // Divider loads the operands set up in the start cycle
    igl_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (x_next),
        .divisor   (y_next),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && !mv_reg && a_pos && b_pos) begin
                    state_next = S_GCD_STEP;
                end
            end
            S_GCD_STEP: begin
                if (y_reg == '0) begin
                    state_next = (cmd_reg == CMD_LCM) ? S_DIV : S_DONE;
                end else begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = lcmdiv_reg ? S_MUL : S_GCD_STEP;
                end
            end
            S_MUL: begin
                if (mq_reg == '0 || ovf_reg) begin
                    state_next = S_DONE;
                end
            end
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        x_next      = x_reg;
        y_next      = y_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        cmd_next    = cmd_reg;
        lcmdiv_next = lcmdiv_reg;
        acc_next    = acc_reg;
        mq_next     = mq_reg;
        mb_next     = mb_reg;
        ovf_next    = ovf_reg;
        out_next    = out_reg;
        mv_next     = mv_reg;
        div_start   = 1'b0;
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid && !mv_reg) begin
                    cmd_next    = s_data.command;
                    a_next      = op_a;
                    b_next      = op_b;
                    lcmdiv_next = 1'b0;
                    ovf_next    = 1'b0;
                    if (op_a < op_b) begin
                        x_next = op_b;
                        y_next = op_a;
                    end else begin
                        x_next = op_a;
                        y_next = op_b;
                    end
                    if (!(a_pos && b_pos)) begin
                        out_next.value  = '0;
                        out_next.status = ST_UNDEF;
                        mv_next         = 1'b1;
                    end
                end
            end
            S_GCD_STEP: begin
                // y == 0 means x holds the gcd
                if (y_reg == '0) begin
                    if (cmd_reg == CMD_LCM) begin
                        lcmdiv_next = 1'b1;
                        y_next      = x_reg;
                        x_next      = a_reg;
                        div_start   = 1'b1;
                    end
                end else begin
                    div_start = 1'b1;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (lcmdiv_reg) begin
                        acc_next = '0;
                        mq_next  = div_q;
                        mb_next  = {1'b0, b_reg};
                    end else begin
                        x_next = y_reg;
                        y_next = div_r;
                    end
                end
            end
            S_MUL: begin
                // Shift-add; any excursion past MAX_POS is an overflow
                if (mq_reg != '0 && !ovf_reg) begin
                    if (mq_reg[0]) begin
                        acc_next = acc_sum;
                        if (acc_sum > {1'b0, MAX_POS}) begin
                            ovf_next = 1'b1;
                        end
                    end
                    mq_next = mq_reg >> 1;
                    if (mq_reg[DATA_WIDTH-1:1] != '0) begin
                        if (mb_reg > {1'b0, MAX_POS}) begin
                            ovf_next = 1'b1;
                        end
                        mb_next = {mb_reg[DATA_WIDTH-1:0], 1'b0};
                    end
                end
            end
            S_DONE: begin
                mv_next = 1'b1;
                if (cmd_reg == CMD_GCD) begin
                    out_next.value  = 63'(x_reg);
                    out_next.status = ST_OK;
                end else if (ovf_reg) begin
                    out_next.value  = '0;
                    out_next.status = ST_OVERFLOW;
                end else begin
                    out_next.value  = 63'(acc_reg[DATA_WIDTH-1:0]);
                    out_next.status = ST_OK;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        cmd_reg    <= cmd_next;
        lcmdiv_reg <= lcmdiv_next;
        acc_reg    <= acc_next;
        mq_reg     <= mq_next;
        mb_reg     <= mb_next;
        ovf_reg    <= ovf_next;
        out_reg    <= out_next;
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE) && !mv_reg;
    assign m_valid = mv_reg;
    assign m_data  = out_reg;

    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status != 2'd3) else $error("bad status");
    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.value == '0) else $error("value not 0");
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE |-> !s_ready) else $error("ready while busy");
    a_done_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE |=> m_valid) else $error("no result after done");

endmodule

[design/igl_divider.sv]
// Restoring divider for integer_gcd_lcm: one quotient bit per cycle.
// Depends on igl_pkg.
module igl_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [igl_pkg::DATA_WIDTH-1:0] dividend,
    input  logic [igl_pkg::DATA_WIDTH-1:0] divisor,
    output logic                          done,
    output logic [igl_pkg::DATA_WIDTH-1:0] quotient,
    output logic [igl_pkg::DATA_WIDTH-1:0] remainder
);
    import igl_pkg::*;

    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] quo_reg, quo_next;
    logic [DATA_WIDTH-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   shifted;

    // Load operands on start, else one shift-subtract step while busy
    always_comb begin
        shifted   = {rem_reg, quo_reg[DATA_WIDTH-1]};
        trial     = shifted - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DATA_WIDTH);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial[DATA_WIDTH]) begin
                rem_next = shifted[DATA_WIDTH-1:0];
                quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b0};
            end else begin
                rem_next = trial[DATA_WIDTH-1:0];
                quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg)) else $error("done without busy");
    a_no_busy_done: assert property (@(posedge aclk) disable iff (!aresetn)
        !(busy_reg && done_reg)) else $error("busy and done together");
    a_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !start |-> cnt_reg != '0) else $error("counter underflow");

endmodule
